/* rtl/core/tms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_pkg
// Types and constants shared by the tabu move selector modules.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int POS_W          = 8;
    localparam int ELEM_W         = 16;
    localparam int FIT_W          = 32;
    localparam int TABU_DEPTH_DEF = 16;

    // Command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Fitness value that means "no move"
    localparam logic [FIT_W-1:0] FIT_NONE = '1;

    typedef struct packed {
        logic              cmd;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
        logic [FIT_W-1:0]  fitness_value;
        logic              round_end;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  move_pos_a;
        logic [POS_W-1:0]  move_pos_b;
        logic [FIT_W-1:0]  move_fitness;
        logic              move_found;
        logic              best_improved;
        logic [FIT_W-1:0]  best_fitness_out;
    } t_out_item;

    // Request from the selector to the tabu ring
    typedef struct packed {
        logic              clear;
        logic [ELEM_W-1:0] hi;
        logic [ELEM_W-1:0] lo;
    } t_ring_req;

endpackage

/* rtl/core/tms_tabu_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_tabu_ring
// Ring of normalized element pairs with valid bits, a parallel lookup of
// the requested pair and a wrapping write pointer.
// ----------------------------------------------------------------------------
module tms_tabu_ring #(
    parameter int TABU_DEPTH = tms_pkg::TABU_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tms_pkg::t_ring_req i_req,
    input  logic               i_push,
    output logic               o_hit
);
    import tms_pkg::*;

    localparam int PTR_W = (TABU_DEPTH > 1) ? $clog2(TABU_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TABU_DEPTH - 1);

    logic [ELEM_W-1:0]     r_high [TABU_DEPTH];
    logic [ELEM_W-1:0]     r_low  [TABU_DEPTH];
    logic [TABU_DEPTH-1:0] r_valid;
    logic [PTR_W-1:0]      r_ptr;
    logic [PTR_W-1:0]      n_ptr;

    // Match the pair against every valid entry
    always_comb begin
        o_hit = 1'b0;
        for (int i = 0; i < TABU_DEPTH; i++) begin
            if (r_valid[i] && r_high[i] == i_req.hi && r_low[i] == i_req.lo) begin
                o_hit = 1'b1;
            end
        end
    end

    // Advance the write pointer with wrap
    always_comb begin
        if (r_ptr == PTR_LAST) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    // Clear or fill the valid bits and move the pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (i_push) begin
            r_valid[r_ptr] <= 1'b1;
            r_ptr          <= n_ptr;
        end
    end

    // Store the pair at the write slot
    always_ff @(posedge i_clk) begin
        if (i_push && !i_req.clear) begin
            r_high[r_ptr] <= i_req.hi;
            r_low[r_ptr]  <= i_req.lo;
        end
    end

endmodule

/* rtl/core/tabu_move_selector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabu_move_selector_top
// Picks the best allowed swap move of each tabu search round.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the input does not stall. An
// accepted item lands in an input register and is processed out of it; the pair lookup
// over all TABU_DEPTH ring entries, the aspiration check and the round
// minimum update run in one pass; a round result is loaded into the output
// register when its closing sample is processed from the input register. Start and
// non-closing samples keep flowing while a result waits; only a closing
// sample waits for the output register to drain, and the input then stalls.
// ----------------------------------------------------------------------------
module tabu_move_selector_top #(
    parameter int TABU_DEPTH = tms_pkg::TABU_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tms_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tms_pkg::t_out_item o_out_item
);
    import tms_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [FIT_W-1:0]  r_round_min;
    logic [POS_W-1:0]  r_round_pa;
    logic [POS_W-1:0]  r_round_pb;
    logic [FIT_W-1:0]  r_best;

    logic              n_out_valid;
    t_out_item         n_out;
    logic [FIT_W-1:0]  n_round_min;
    logic [POS_W-1:0]  n_round_pa;
    logic [POS_W-1:0]  n_round_pb;
    logic [FIT_W-1:0]  n_best;

    logic              is_sample;
    logic              makes_result;
    logic              consume;
    logic              in_take;
    logic              out_take;
    logic              hit;
    logic              rejected;
    logic [FIT_W-1:0]  eff_fit;
    logic              upd;
    logic              improved;
    t_ring_req         ring_req;
    logic              ring_push;

    // Handshake: drain the input register unless its result has no room
    assign is_sample    = (r_in.cmd == CMD_SAMPLE);
    assign makes_result = is_sample && r_in.round_end;
    assign out_take     = r_out_valid && !i_out_stall;
    assign consume      = r_in_valid && (!makes_result || !r_out_valid || !i_out_stall);
    assign o_in_stall   = r_in_valid && !consume;
    assign in_take      = i_in_valid && !o_in_stall;

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
    end

    // Normalize the pair and drive the ring
    always_comb begin
        ring_req.clear = consume && !is_sample;
        ring_req.hi    = (r_in.elem_a > r_in.elem_b) ? r_in.elem_a : r_in.elem_b;
        ring_req.lo    = (r_in.elem_a > r_in.elem_b) ? r_in.elem_b : r_in.elem_a;
    end

    assign ring_push = consume && is_sample && !rejected;

    tms_tabu_ring #(
        .TABU_DEPTH(TABU_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (ring_req),
        .i_push (ring_push),
        .o_hit  (hit)
    );

    // Apply aspiration, track the round minimum and close the round
    always_comb begin
        rejected    = hit && (r_in.fitness_value >= r_best);
        eff_fit     = rejected ? FIT_NONE : r_in.fitness_value;
        upd         = eff_fit < r_round_min;
        n_round_min = upd ? eff_fit : r_round_min;
        n_round_pa  = upd ? r_in.pos_a : r_round_pa;
        n_round_pb  = upd ? r_in.pos_b : r_round_pb;
        improved    = n_round_min < r_best;
        n_best      = r_best;

        n_out.move_pos_a       = n_round_pa;
        n_out.move_pos_b       = n_round_pb;
        n_out.move_fitness     = n_round_min;
        n_out.move_found       = (n_round_min != FIT_NONE);
        n_out.best_improved    = improved;
        n_out.best_fitness_out = improved ? n_round_min : r_best;

        if (!is_sample) begin
            n_round_min = FIT_NONE;
            n_round_pa  = '0;
            n_round_pb  = '0;
            n_best      = r_in.fitness_value;
        end else if (r_in.round_end) begin
            n_best      = n_out.best_fitness_out;
            n_round_min = FIT_NONE;
            n_round_pa  = '0;
            n_round_pb  = '0;
        end
    end

    // Update the search state on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_min <= FIT_NONE;
            r_round_pa  <= '0;
            r_round_pb  <= '0;
            r_best      <= FIT_NONE;
        end else if (consume) begin
            r_round_min <= n_round_min;
            r_round_pa  <= n_round_pa;
            r_round_pb  <= n_round_pb;
            r_best      <= n_best;
        end
    end

    // Load or drop the result register
    always_comb begin
        if (consume && makes_result) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && makes_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    a_found_matches_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.move_found == (o_out_item.move_fitness != FIT_NONE)))
        else $error("move_found disagrees with move_fitness");

    a_improved_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.best_improved)
            |-> (o_out_item.best_fitness_out == o_out_item.move_fitness))
        else $error("improved best does not equal chosen fitness");

    a_start_loads_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && !is_sample) |=> (r_best == $past(r_in.fitness_value)))
        else $error("start item did not load best fitness");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_out)))
        else $error("waiting result lost or overwritten");

endmodule
